### src/led_matrix_scroller_top_defines.svh
// Assertion macros shared by the LED matrix scroller RTL.
// No dependencies; taken in by the files that carry assertions.
`ifndef LED_MATRIX_SCROLLER_TOP_DEFINES_SVH
`define LED_MATRIX_SCROLLER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LMS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lms assertion failed");

// next-cycle implication, disabled in reset
`define LMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lms assertion failed");

`endif

### src/lms_pkg.sv
// Shared types and constants for the LED matrix scroller.
// No dependencies; imported by every module and interface of the block.
package lms_pkg;

   localparam int MAX_POSITIONS_DEFAULT = 8;

   localparam int OP_W       = 2;
   localparam int POS_FIELD_W = 3;
   localparam int ROW_W      = 3;
   localparam int PIX_W      = 8;
   localparam int LENGTH_W   = 4;
   localparam int DIVIDE_W   = 8;
   localparam int OFFSET_W   = 3;
   localparam int ROWS       = 8;
   localparam int GLYPH_W    = ROWS * PIX_W;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_MESSAGE_LENGTH = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCROLL_DIVIDE  = 1'b1;

   localparam logic [LENGTH_W-1:0] LENGTH_RESET = 4'd8;
   localparam logic [DIVIDE_W-1:0] DIVIDE_RESET = 8'd10;
   localparam logic [PIX_W-1:0]    SELECT_RESET = 8'hfe;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD    = 2'd0,
      OP_TICK    = 2'd1,
      OP_REFRESH = 2'd2,
      OP_SCROLL  = 2'd3
   } op_type;

   typedef struct packed {
      op_type                 operation;
      logic [POS_FIELD_W-1:0] position;
      logic [ROW_W-1:0]       row_index;
      logic [PIX_W-1:0]       pattern_byte;
   } item_type;

   typedef struct packed {
      logic [PIX_W-1:0] row_bits;
      logic [PIX_W-1:0] select_lines;
   } result_type;

   // one byte-lane write into the glyph store
   typedef struct packed {
      logic                   en;
      logic [POS_FIELD_W-1:0] pos;
      logic [ROW_W-1:0]       row;
      logic [PIX_W-1:0]       data;
   } glyph_wr_type;

endpackage

### src/lms_req_if.sv
// Request channel of the LED matrix scroller: valid/ready plus one input beat.
// Depends on lms_pkg.
interface lms_req_if import lms_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [OP_W-1:0]        operation;
   logic [POS_FIELD_W-1:0] position;
   logic [ROW_W-1:0]       row_index;
   logic [PIX_W-1:0]       pattern_byte;

   modport source (output valid, operation, position, row_index, pattern_byte,
                   input ready);
   modport sink   (input valid, operation, position, row_index, pattern_byte,
                   output ready);
endinterface

### src/lms_rsp_if.sv
// Response channel of the LED matrix scroller: valid/ready plus one result beat.
// Depends on lms_pkg.
interface lms_rsp_if import lms_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] row_bits;
   logic [PIX_W-1:0] select_lines;

   modport source (output valid, row_bits, select_lines, input ready);
   modport sink   (input valid, row_bits, select_lines, output ready);
endinterface

### src/lms_glyph_mem.sv
// Glyph store: one 64-bit word per message position, byte-lane writes and
// two registered read ports with same-edge write forwarding. Depends on lms_pkg.
module lms_glyph_mem import lms_pkg::*; #(
   parameter int MAX_POSITIONS = MAX_POSITIONS_DEFAULT
) (
   input  logic                             clock,
   input  glyph_wr_type                     wr,
   input  logic [$clog2(MAX_POSITIONS)-1:0] cur_addr,
   input  logic [$clog2(MAX_POSITIONS)-1:0] nxt_addr,
   output logic [GLYPH_W-1:0]               cur_glyph,
   output logic [GLYPH_W-1:0]               nxt_glyph
);
   localparam int PosW = $clog2(MAX_POSITIONS);

   logic [GLYPH_W-1:0] mem_ff [MAX_POSITIONS];
   logic [GLYPH_W-1:0] cur_ff;
   logic [GLYPH_W-1:0] nxt_ff;
   logic [PosW-1:0]    wr_addr;

   assign wr_addr = PosW'(wr.pos);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr_addr][{wr.row, 3'b000} +: PIX_W] <= wr.data;
      end
   end

   // reads see a load that lands on the same edge
   always_ff @(posedge clock) begin
      cur_ff <= mem_ff[cur_addr];
      nxt_ff <= mem_ff[nxt_addr];
      if (wr.en && (wr_addr == cur_addr)) begin
         cur_ff[{wr.row, 3'b000} +: PIX_W] <= wr.data;
      end
      if (wr.en && (wr_addr == nxt_addr)) begin
         nxt_ff[{wr.row, 3'b000} +: PIX_W] <= wr.data;
      end
   end

   assign cur_glyph = cur_ff;
   assign nxt_glyph = nxt_ff;
endmodule

### src/lms_core.sv
// Scroller state and per-beat update: prescaler, scroll blend, scan refresh.
// Depends on lms_pkg and the assertion macros header.
`include "led_matrix_scroller_top_defines.svh"
module lms_core import lms_pkg::*; #(
   parameter int MAX_POSITIONS = MAX_POSITIONS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fire,
   input  item_type                         item,
   input  logic [LENGTH_W-1:0]              len_ff,
   input  logic [LENGTH_W-1:0]              len_in,
   input  logic [DIVIDE_W-1:0]              divide_ff,
   input  logic [GLYPH_W-1:0]               cur_glyph,
   input  logic [GLYPH_W-1:0]               nxt_glyph,
   output logic [$clog2(MAX_POSITIONS)-1:0] cur_addr,
   output logic [$clog2(MAX_POSITIONS)-1:0] nxt_addr,
   output glyph_wr_type                     wr,
   output result_type                       result
);
   localparam int PosW = $clog2(MAX_POSITIONS);

   logic [PIX_W-1:0]    frame_ff [ROWS];
   logic [PIX_W-1:0]    frame_in [ROWS];
   logic [PosW-1:0]     pos_ff, pos_in;
   logic [OFFSET_W-1:0] off_ff, off_in;
   logic [DIVIDE_W-1:0] tick_ff, tick_in;
   logic [PIX_W-1:0]    sel_ff, sel_in;
   logic [ROW_W-1:0]    scan_ff, scan_in;
   logic [DIVIDE_W-1:0] tick_inc;
   logic [PosW-1:0]     nxt_pos;
   logic                scroll;

   // position after p, wrapping at the length saturated to the store depth
   function automatic logic [PosW-1:0] step_pos(input logic [PosW-1:0] p,
                                                input logic [LENGTH_W-1:0] len);
      logic [PosW:0] inc;
      logic [PosW:0] lim;
      inc = {1'b0, p} + 1'b1;
      if (int'(len) > MAX_POSITIONS) begin
         lim = (PosW+1)'(MAX_POSITIONS);
      end else begin
         lim = (PosW+1)'(len);
      end
      return (inc >= lim) ? '0 : inc[PosW-1:0];
   endfunction

   assign nxt_pos  = step_pos(pos_ff, len_ff);
   assign tick_inc = tick_ff + 1'b1;

   always_comb begin
      logic [PIX_W-1:0] a;
      logic [PIX_W-1:0] b;
      logic [PIX_W-1:0] v;
      a       = '0;
      b       = '0;
      v       = '0;
      pos_in  = pos_ff;
      off_in  = off_ff;
      tick_in = tick_ff;
      sel_in  = sel_ff;
      scan_in = scan_ff;
      scroll  = 1'b0;
      wr      = '0;
      for (int r = 0; r < ROWS; r++) begin
         frame_in[r] = frame_ff[r];
      end
      if (fire) begin
         unique case (item.operation)
            OP_LOAD: begin
               wr.en   = int'(item.position) < MAX_POSITIONS;
               wr.pos  = item.position;
               wr.row  = item.row_index;
               wr.data = item.pattern_byte;
            end
            OP_TICK: begin
               tick_in = tick_inc;
               if (tick_inc == divide_ff) begin
                  tick_in = '0;
                  scroll  = 1'b1;
               end
            end
            OP_REFRESH: begin
               sel_in  = {sel_ff[PIX_W-2:0], sel_ff[PIX_W-1]};
               scan_in = scan_ff + 1'b1;
            end
            OP_SCROLL: begin
               scroll = 1'b1;
            end
            default: begin
               scroll = 1'b0;
            end
         endcase
      end
      if (scroll) begin
         for (int r = 0; r < ROWS; r++) begin
            a = cur_glyph[r*PIX_W +: PIX_W];
            b = nxt_glyph[r*PIX_W +: PIX_W];
            v = a << off_ff;
            if (off_ff != '0) begin
               v = v | (b >> (4'd8 - {1'b0, off_ff}));
            end
            frame_in[r] = v;
         end
         off_in = off_ff + 1'b1;
         if (off_ff == 3'd7) begin
            pos_in = nxt_pos;
         end
      end
   end

   // glyph reads are issued for the state that the next beat will see
   assign cur_addr = pos_in;
   assign nxt_addr = step_pos(pos_in, len_in);

   assign result.select_lines = {sel_ff[PIX_W-2:0], sel_ff[PIX_W-1]};
   assign result.row_bits     = frame_ff[ROW_W'(scan_ff + 1'b1)];

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         off_ff  <= '0;
         tick_ff <= '0;
         sel_ff  <= SELECT_RESET;
         scan_ff <= '0;
         for (int r = 0; r < ROWS; r++) begin
            frame_ff[r] <= '0;
         end
      end else begin
         pos_ff  <= pos_in;
         off_ff  <= off_in;
         tick_ff <= tick_in;
         sel_ff  <= sel_in;
         scan_ff <= scan_in;
         for (int r = 0; r < ROWS; r++) begin
            frame_ff[r] <= frame_in[r];
         end
      end
   end

   `LMS_ASSERT_NOW(a_one_select_low, clock, reset, 1'b1, $countones(~sel_ff) == 1)
   `LMS_ASSERT_NEXT(a_wrap_moves_pos, clock, reset, scroll && (off_ff == 3'd7), pos_ff == $past(nxt_pos))
   `LMS_ASSERT_NEXT(a_pos_still, clock, reset, !scroll, pos_ff == $past(pos_ff))
endmodule

### src/led_matrix_scroller_top.sv
// Top level of the LED matrix scroller: input and result registers, CSRs,
// state core and glyph store. Depends on lms_pkg, the channel interfaces,
// lms_core, lms_glyph_mem and the assertion macros header.
//
//   channel  dir  handshake      payload
//   req_bus  in   valid/ready    operation, position, row_index, pattern_byte
//   rsp_bus  out  valid/ready    row_bits, select_lines
//   csr_*    in   write enable   csr_index, csr_write_data
//
// One beat accepted per cycle unless a refresh beat is held back (below);
// a refresh result goes through the input register, then the result register.
// The glyph store's registered two-port read is launched at the accept edge
// with the state the beat will see, so a scroll step needs no read wait.
// A refresh beat waits in the input register while the result register is
// full and not being taken, and holds off the beats behind it; other beats
// never wait in the input register.
// Synchronous active-high reset clears all control state; the glyph store
// is not cleared.
`include "led_matrix_scroller_top_defines.svh"
module led_matrix_scroller_top import lms_pkg::*; #(
   parameter int MAX_POSITIONS = MAX_POSITIONS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   lms_req_if.sink                req_bus,
   lms_rsp_if.source              rsp_bus,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);
   localparam int PosW = $clog2(MAX_POSITIONS);

   logic [LENGTH_W-1:0] len_ff, len_in;
   logic [DIVIDE_W-1:0] divide_ff, divide_in;
   item_type            item_ff;
   logic                item_valid_ff;
   result_type          rsp_data_ff;
   logic                rsp_valid_ff;
   logic                out_free;
   logic                fire;
   logic                refresh_fire;
   logic                accept;
   result_type          result;
   glyph_wr_type        wr;
   logic [PosW-1:0]     cur_addr, nxt_addr;
   logic [GLYPH_W-1:0]  cur_glyph, nxt_glyph;

   assign len_in = (csr_write_en && (csr_index == CSR_MESSAGE_LENGTH))
                   ? csr_write_data[LENGTH_W-1:0] : len_ff;
   assign divide_in = (csr_write_en && (csr_index == CSR_SCROLL_DIVIDE))
                      ? csr_write_data[DIVIDE_W-1:0] : divide_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= LENGTH_RESET;
         divide_ff <= DIVIDE_RESET;
      end else begin
         len_ff    <= len_in;
         divide_ff <= divide_in;
      end
   end

   assign out_free     = !rsp_valid_ff || rsp_bus.ready;
   assign fire         = item_valid_ff && ((item_ff.operation != OP_REFRESH) || out_free);
   assign refresh_fire = fire && (item_ff.operation == OP_REFRESH);
   assign req_bus.ready = !item_valid_ff || fire;
   assign accept        = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (accept) begin
         item_valid_ff <= 1'b1;
      end else if (fire) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.operation    <= op_type'(req_bus.operation);
         item_ff.position     <= req_bus.position;
         item_ff.row_index    <= req_bus.row_index;
         item_ff.pattern_byte <= req_bus.pattern_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (refresh_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (refresh_fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.row_bits     = rsp_data_ff.row_bits;
   assign rsp_bus.select_lines = rsp_data_ff.select_lines;

   lms_core #(
      .MAX_POSITIONS(MAX_POSITIONS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (item_ff),
      .len_ff    (len_ff),
      .len_in    (len_in),
      .divide_ff (divide_ff),
      .cur_glyph (cur_glyph),
      .nxt_glyph (nxt_glyph),
      .cur_addr  (cur_addr),
      .nxt_addr  (nxt_addr),
      .wr        (wr),
      .result    (result)
   );

   lms_glyph_mem #(
      .MAX_POSITIONS(MAX_POSITIONS)
   ) u_glyph_mem (
      .clock     (clock),
      .wr        (wr),
      .cur_addr  (cur_addr),
      .nxt_addr  (nxt_addr),
      .cur_glyph (cur_glyph),
      .nxt_glyph (nxt_glyph)
   );

   `LMS_ASSERT_NEXT(a_refresh_loads_rsp, clock, reset, refresh_fire, rsp_valid_ff)
   `LMS_ASSERT_NOW(a_blocked_refresh_holds, clock, reset, item_valid_ff && (item_ff.operation == OP_REFRESH) && !out_free, !req_bus.ready)
   `LMS_ASSERT_NOW(a_no_write_unless_load, clock, reset, wr.en, fire && (item_ff.operation == OP_LOAD))
endmodule

### tb/lms_scoreboard_pkg.sv
// Scoreboard for the LED matrix scroller testbench: mirrors glyph store,
// frame rows and scan state, and queues the expected refresh rows.
// Depends on lms_pkg.
`timescale 1ns / 1ps
package lms_scoreboard_pkg;
   import lms_pkg::*;

   class frame_scoreboard;
      logic [PIX_W-1:0]      glyphs [MAX_POSITIONS_DEFAULT*ROWS];
      bit                    loaded [MAX_POSITIONS_DEFAULT*ROWS];
      logic [PIX_W-1:0]      frame [ROWS];
      logic [POS_FIELD_W-1:0] position;
      logic [OFFSET_W-1:0]   offset;
      logic [ROW_W-1:0]      scan_row;
      logic [DIVIDE_W-1:0]   ticks;
      logic [PIX_W-1:0]      select;
      logic [LENGTH_W-1:0]   length;
      logic [DIVIDE_W-1:0]   divide;
      result_type            pending_rows [$];
      int unsigned           mismatches;
      int unsigned           rows_checked;

      function new();
         foreach (glyphs[i]) begin
            glyphs[i] = '0;
            loaded[i] = 1'b0;
         end
         foreach (frame[i]) frame[i] = '0;
         position     = '0;
         offset       = '0;
         scan_row     = '0;
         ticks        = '0;
         select       = SELECT_RESET;
         length       = LENGTH_RESET;
         divide       = DIVIDE_RESET;
         mismatches   = 0;
         rows_checked = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         if (index == CSR_MESSAGE_LENGTH)
            length = data[LENGTH_W-1:0];
         else if (index == CSR_SCROLL_DIVIDE)
            divide = data[DIVIDE_W-1:0];
      endfunction

      // length saturates at the store size; zero length always wraps to 0
      function logic [POS_FIELD_W-1:0] next_position();
         int unsigned span;
         span = (length > MAX_POSITIONS_DEFAULT) ? MAX_POSITIONS_DEFAULT : length;
         if (int'(position) + 1 >= span)
            return '0;
         return position + 1'b1;
      endfunction

      function bit tick_scrolls();
         logic [DIVIDE_W-1:0] bumped;
         bumped = ticks + 1'b1;
         return bumped == divide;
      endfunction

      // true when a scroll now touches only loaded glyph rows
      function bit glyphs_ready();
         logic [POS_FIELD_W-1:0] upcoming;
         upcoming = next_position();
         for (int r = 0; r < ROWS; r++) begin
            if (!loaded[{position, r[ROW_W-1:0]}] || !loaded[{upcoming, r[ROW_W-1:0]}])
               return 1'b0;
         end
         return 1'b1;
      endfunction

      function void missing_entry(output logic [POS_FIELD_W-1:0] pos,
                                  output logic [ROW_W-1:0] row);
         logic [POS_FIELD_W-1:0] upcoming;
         upcoming = next_position();
         pos = position;
         row = '0;
         for (int r = ROWS-1; r >= 0; r--) begin
            if (!loaded[{upcoming, r[ROW_W-1:0]}]) begin
               pos = upcoming;
               row = r[ROW_W-1:0];
            end
         end
         for (int r = ROWS-1; r >= 0; r--) begin
            if (!loaded[{position, r[ROW_W-1:0]}]) begin
               pos = position;
               row = r[ROW_W-1:0];
            end
         end
      endfunction

      function void scroll_step();
         logic [POS_FIELD_W-1:0] upcoming;
         logic [PIX_W-1:0]       left;
         logic [PIX_W-1:0]       right;
         logic [PIX_W-1:0]       blended;
         upcoming = next_position();
         for (int r = 0; r < ROWS; r++) begin
            left    = glyphs[{position, r[ROW_W-1:0]}];
            right   = glyphs[{upcoming, r[ROW_W-1:0]}];
            blended = left << offset;
            // offset zero shows the current glyph alone
            if (offset != 0)
               blended = blended | (right >> (PIX_W - offset));
            frame[r] = blended;
         end
         offset = offset + 1'b1;
         if (offset == 0)
            position = upcoming;
      endfunction

      function void note_input(item_type beat);
         case (beat.operation)
            OP_LOAD: begin
               glyphs[{beat.position, beat.row_index}] = beat.pattern_byte;
               loaded[{beat.position, beat.row_index}] = 1'b1;
            end
            OP_TICK: begin
               ticks = ticks + 1'b1;
               if (ticks == divide) begin
                  ticks = '0;
                  scroll_step();
               end
            end
            OP_SCROLL: begin
               scroll_step();
            end
            default: begin
               result_type row;
               select   = {select[PIX_W-2:0], select[PIX_W-1]};
               scan_row = scan_row + 1'b1;
               row.row_bits     = frame[scan_row];
               row.select_lines = select;
               pending_rows.push_back(row);
            end
         endcase
      endfunction

      function void check_result(logic [PIX_W-1:0] row_bits, logic [PIX_W-1:0] select_lines);
         result_type want;
         if (pending_rows.size() == 0) begin
            $display("%0t: unexpected result beat, actual row_bits %h select_lines %h",
                     $time, row_bits, select_lines);
            mismatches++;
            return;
         end
         want = pending_rows.pop_front();
         rows_checked++;
         if (row_bits !== want.row_bits) begin
            $display("%0t: row_bits mismatch, expected %h, actual %h",
                     $time, want.row_bits, row_bits);
            mismatches++;
         end
         if (select_lines !== want.select_lines) begin
            $display("%0t: select_lines mismatch, expected %h, actual %h",
                     $time, want.select_lines, select_lines);
            mismatches++;
         end
      endfunction

      function void flush_leftovers();
         while (pending_rows.size() > 0) begin
            result_type want;
            want = pending_rows.pop_front();
            $display("%0t: result never arrived, expected row_bits %h select_lines %h",
                     $time, want.row_bits, want.select_lines);
            mismatches++;
         end
      endfunction
   endclass

endpackage

### tb/led_matrix_scroller_top_tb.sv
// Top of the LED matrix scroller testbench: clock, reset, beat drivers,
// result monitor and stimulus phases. Depends on lms_pkg, the channel
// interfaces, lms_scoreboard_pkg and led_matrix_scroller_top.
`timescale 1ns / 1ps
module led_matrix_scroller_top_tb;
   import lms_pkg::*;
   import lms_scoreboard_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE_TIME  = 8;
   localparam int PHASES       = 9;
   localparam int FLOOD_BEATS  = 48;

   logic clock;
   logic reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   lms_req_if req_bus ();
   lms_rsp_if rsp_bus ();

   led_matrix_scroller_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   frame_scoreboard scoreboard;
   bit              quiet;
   bit              hold_request;
   int unsigned     cycle_count = 0;
   int unsigned     op_count [4];
   int unsigned     settings_used;

   // phase settings: zero, oversized and extreme values included
   int unsigned phase_length [PHASES] = '{1, 8, 0, 15, 5, 2, 9, 3, 8};
   int unsigned phase_divide [PHASES] = '{1, 255, 0, 3, 7, 2, 1, 4, 10};

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** led_matrix_scroller_top: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         scoreboard.check_result(rsp_bus.row_bits, rsp_bus.select_lines);
   end

   // result side back-pressure
   initial begin
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   function automatic item_type make_beat(op_type op, int unsigned pos, int unsigned row,
                                          int unsigned data);
      item_type b;
      b.operation    = op;
      b.position     = pos[POS_FIELD_W-1:0];
      b.row_index    = row[ROW_W-1:0];
      b.pattern_byte = data[PIX_W-1:0];
      return b;
   endfunction

   // weights in percent; a scroll that would touch an unloaded row becomes a load
   function automatic item_type random_beat(int unsigned load_w, int unsigned tick_w,
                                            int unsigned refresh_w);
      item_type    b;
      int unsigned pick;
      logic [POS_FIELD_W-1:0] pos;
      logic [ROW_W-1:0]       row;
      b = make_beat(OP_LOAD, $urandom, $urandom, $urandom);
      pick = $urandom_range(0, 99);
      if (pick < load_w)
         b.operation = OP_LOAD;
      else if (pick < load_w + tick_w)
         b.operation = OP_TICK;
      else if (pick < load_w + tick_w + refresh_w)
         b.operation = OP_REFRESH;
      else
         b.operation = OP_SCROLL;
      if ((b.operation == OP_SCROLL || (b.operation == OP_TICK && scoreboard.tick_scrolls()))
          && !scoreboard.glyphs_ready()) begin
         scoreboard.missing_entry(pos, row);
         b.operation = OP_LOAD;
         b.position  = pos;
         b.row_index = row;
      end
      return b;
   endfunction

   task automatic send_beat(item_type b);
      req_bus.valid        <= 1'b1;
      req_bus.operation    <= b.operation;
      req_bus.position     <= b.position;
      req_bus.row_index    <= b.row_index;
      req_bus.pattern_byte <= b.pattern_byte;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      scoreboard.note_input(b);
      op_count[b.operation]++;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (scoreboard.pending_rows.size() > 0) @(posedge clock);
      repeat (SETTLE_TIME) @(posedge clock);
   endtask

   task automatic write_settings(int unsigned length, int unsigned divide);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_MESSAGE_LENGTH;
      csr_write_data <= length[CSR_DATA_W-1:0];
      @(posedge clock);
      scoreboard.write_register(CSR_MESSAGE_LENGTH, length[CSR_DATA_W-1:0]);
      csr_index      <= CSR_SCROLL_DIVIDE;
      csr_write_data <= divide[CSR_DATA_W-1:0];
      @(posedge clock);
      scoreboard.write_register(CSR_SCROLL_DIVIDE, divide[CSR_DATA_W-1:0]);
      csr_write_en   <= 1'b0;
      settings_used++;
   endtask

   task automatic run_phase(int unsigned idx);
      int unsigned beats;
      int unsigned tick_w;
      write_settings(phase_length[idx], phase_divide[idx]);
      // slow dividers need a tick-heavy mix to reach a scroll
      if (phase_divide[idx] == 0 || phase_divide[idx] > 100) begin
         beats  = 320;
         tick_w = 80;
      end else begin
         beats  = 180;
         tick_w = 25;
      end
      for (int n = 0; n < beats; n++)
         send_beat(random_beat((tick_w == 80) ? 8 : 25, tick_w, (tick_w == 80) ? 8 : 30));
      wait_drained();
   endtask

   task automatic run_directed();
      byte unsigned first_glyph  [ROWS] = '{8'h00, 8'hff, 8'h80, 8'h01,
                                            8'hf0, 8'h0f, 8'haa, 8'h55};
      byte unsigned second_glyph [ROWS] = '{8'hff, 8'h00, 8'h01, 8'h80,
                                            8'h0f, 8'hf0, 8'h55, 8'haa};
      write_settings(8, 2);
      // refresh straight after reset shows the cleared frame
      send_beat(make_beat(OP_REFRESH, 7, 7, 8'hff));
      for (int r = 0; r < ROWS; r++)
         send_beat(make_beat(OP_LOAD, 0, r, first_glyph[r]));
      for (int r = 0; r < ROWS; r++)
         send_beat(make_beat(OP_LOAD, 1, r, second_glyph[r]));
      send_beat(make_beat(OP_SCROLL, 0, 0, 8'h00));
      send_beat(make_beat(OP_REFRESH, 0, 0, 8'h00));
      send_beat(make_beat(OP_SCROLL, 7, 7, 8'hff));
      send_beat(make_beat(OP_TICK, 0, 7, 8'h00));
      send_beat(make_beat(OP_TICK, 7, 0, 8'hff));
      send_beat(make_beat(OP_REFRESH, 3, 4, 8'h5a));
      send_beat(make_beat(OP_REFRESH, 4, 3, 8'ha5));
      wait_drained();
   endtask

   initial begin
      scoreboard           = new();
      quiet                = 1'b0;
      hold_request         = 1'b0;
      settings_used        = 0;
      foreach (op_count[i]) op_count[i] = 0;
      reset                = 1'b1;
      csr_write_en         = 1'b0;
      csr_index            = CSR_MESSAGE_LENGTH;
      csr_write_data       = '0;
      req_bus.valid        = 1'b0;
      req_bus.operation    = OP_LOAD;
      req_bus.position     = '0;
      req_bus.row_index    = '0;
      req_bus.pattern_byte = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      for (int p = 0; p < 4; p++)
         run_phase(p);

      // result side held off while refresh beats keep coming
      hold_request = 1'b1;
      for (int n = 0; n < FLOOD_BEATS; n++)
         send_beat(make_beat(OP_REFRESH, $urandom, $urandom, $urandom));
      wait_drained();

      for (int p = 4; p < PHASES; p++) begin
         if (p == PHASES - 1)
            quiet = 1'b1;
         run_phase(p);
      end

      scoreboard.flush_leftovers();
      $display("Covered %0d loads, %0d ticks, %0d refreshes, %0d scroll requests",
               op_count[OP_LOAD], op_count[OP_TICK], op_count[OP_REFRESH], op_count[OP_SCROLL]);
      $display("over %0d register settings; %0d scanned rows compared",
               settings_used, scoreboard.rows_checked);
      if (scoreboard.mismatches == 0)
         $display("** led_matrix_scroller_top: PASSED **");
      else
         $display("** led_matrix_scroller_top: FAILED **");
      $finish;
   end

endmodule
